// File: sv/lpht_pkg.sv
package lpht_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TEXT_BYTES  = 8;

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int SIZE_W   = $clog2(TABLE_DEPTH + 1);
    localparam int OP_W     = 2;
    localparam int KEY_W    = 31;
    localparam int TEXT_W   = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    // The remainder unit eats two key bits per cycle.
    localparam int MOD_STEPS = (KEY_W + 1) / 2;
    localparam int MOD_SH_W  = 2 * MOD_STEPS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    localparam logic [TEXT_W-1:0] TEXT_MASK =
        {TEXT_W{1'b1}} >> (TEXT_W - 8 * TEXT_BYTES);

    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_RESET =
        (TABLE_DEPTH < 16) ? SIZE_W'(TABLE_DEPTH) : SIZE_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_DUMP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 3'd0,
        ST_FULL       = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_DUMP_ENTRY = 3'd3,
        ST_DUMP_EMPTY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SRC_ENTRY = 2'd0,
        SRC_INPUT = 2'd1,
        SRC_BLANK = 2'd2
    } src_t;

    typedef struct packed {
        logic    load;
        logic    mod_step;
        logic    probe_init;
        logic    dump_init;
        logic    advance;
        logic    store;
        logic    del_clear;
        logic    shift_move;
        logic    emit;
        src_t    emit_src;
        status_t emit_status;
        logic    emit_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic mod_done;
        logic n_end;
        logic occ;
        logic key_match;
        logic can_move;
        logic later_occ;
        logic out_free;
    } stat_t;

endpackage

// File: sv/lpht_req_if.sv
interface lpht_req_if
    import lpht_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [TEXT_W-1:0] text;

    modport source (output valid, output operation, output key, output text, input ready);
    modport sink   (input valid, input operation, input key, input text, output ready);
endinterface

// File: sv/lpht_rsp_if.sv
interface lpht_rsp_if
    import lpht_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    entry_key;
    logic [TEXT_W-1:0]   entry_text;
    logic                last;

    modport source (output valid, output status, output slot, output entry_key,
                    output entry_text, output last, input ready);
    modport sink   (input valid, input status, input slot, input entry_key,
                    input entry_text, input last, output ready);
endinterface

// File: sv/lpht_mod.sv
module lpht_mod
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              step,
    input  logic [KEY_W-1:0]  key,
    input  logic [SIZE_W-1:0] size,
    output logic [IDX_W-1:0]  rem,
    output logic              done
);

    localparam int RW = SIZE_W + 1;

    logic [MOD_SH_W-1:0]  sh_reg, sh_next;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]        part_a, part_b;

    // Two restoring steps per cycle; the partial remainder stays below size.
    always_comb
    begin
        part_a = (RW'(rem_reg) << 1) | RW'(sh_reg[MOD_SH_W-1]);
        if (part_a >= RW'(size))
        begin
            part_a = part_a - RW'(size);
        end
        part_b = (part_a << 1) | RW'(sh_reg[MOD_SH_W-2]);
        if (part_b >= RW'(size))
        begin
            part_b = part_b - RW'(size);
        end

        sh_next  = sh_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            sh_next  = MOD_SH_W'(key);
            rem_next = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            sh_next  = sh_reg << 2;
            rem_next = IDX_W'(part_b);
            cnt_next = cnt_reg + MOD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= MOD_CNT_W'(MOD_STEPS);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = (cnt_reg == MOD_CNT_W'(MOD_STEPS));

endmodule

// File: sv/lpht_ctrl.sv
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  op_t   in_op,
    output logic  in_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_PROBE = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DUMP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   any_reg, any_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        any_next   = any_reg;
        in_ready   = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (in_op == OP_ADD || in_op == OP_DEL)
                    begin
                        state_next = S_HASH;
                    end
                    else if (in_op == OP_DUMP)
                    begin
                        cmd.dump_init = 1'b1;
                        any_next      = 1'b0;
                        state_next    = S_DUMP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_HASH:
            begin
                if (stat.mod_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_PROBE;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_PROBE:
            begin
                if (stat.op == OP_ADD)
                begin
                    priority if (stat.n_end)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_src    = SRC_BLANK;
                            cmd.emit_status = ST_FULL;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    else if (!stat.occ)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.store       = 1'b1;
                            cmd.emit        = 1'b1;
                            cmd.emit_src    = SRC_INPUT;
                            cmd.emit_status = ST_DONE;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else
                begin
                    priority if (stat.n_end || !stat.occ)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_src    = SRC_BLANK;
                            cmd.emit_status = ST_NOT_FOUND;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    else if (stat.key_match)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_src    = SRC_ENTRY;
                            cmd.emit_status = ST_DONE;
                            cmd.emit_last   = 1'b1;
                            cmd.del_clear   = 1'b1;
                            state_next      = S_SHIFT;
                        end
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_SHIFT:
            begin
                if (stat.n_end || !stat.occ)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.shift_move = stat.can_move;
                    cmd.advance    = 1'b1;
                end
            end
            S_DUMP:
            begin
                priority if (stat.n_end)
                begin
                    if (any_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_src    = SRC_BLANK;
                        cmd.emit_status = ST_DUMP_EMPTY;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.occ)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_src    = SRC_ENTRY;
                        cmd.emit_status = ST_DUMP_ENTRY;
                        cmd.emit_last   = !stat.later_occ;
                        cmd.advance     = 1'b1;
                        any_next        = 1'b1;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            any_reg   <= any_next;
        end
    end

endmodule

// File: sv/lpht_dp.sv
module lpht_dp
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_size,
    output logic [SIZE_W-1:0] size,
    input  op_t               in_op,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [TEXT_W-1:0] in_text,
    input  cmd_t              cmd,
    output stat_t             stat,
    lpht_rsp_if.source        rsp
);

    logic [SIZE_W-1:0]      size_reg;
    logic [TABLE_DEPTH-1:0] occ_reg, occ_next;
    logic [KEY_W-1:0]       key_mem  [TABLE_DEPTH];
    logic [TEXT_W-1:0]      text_mem [TABLE_DEPTH];
    logic [IDX_W-1:0]       home_mem [TABLE_DEPTH];

    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TEXT_W-1:0] text_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  hole_reg, hole_next;
    logic [SIZE_W-1:0] n_reg, n_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic [TEXT_W-1:0]   out_text_reg;
    logic                out_last_reg;

    logic [IDX_W-1:0]       rem;
    logic                   mod_done;
    logic [SIZE_W-1:0]      idx_inc;
    logic [IDX_W-1:0]       idx_wrap;
    logic [KEY_W-1:0]       rd_key;
    logic [TEXT_W-1:0]      rd_text;
    logic [IDX_W-1:0]       rd_home;
    logic [SIZE_W:0]        dist_home, dist_hole;
    logic [TABLE_DEPTH-1:0] later_mask;

    lpht_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .step  (cmd.mod_step),
        .key   (in_key),
        .size  (size_reg),
        .rem   (rem),
        .done  (mod_done)
    );

    assign rd_key  = key_mem[idx_reg];
    assign rd_text = text_mem[idx_reg];
    assign rd_home = home_mem[idx_reg];

    assign idx_inc  = SIZE_W'(idx_reg) + SIZE_W'(1);
    assign idx_wrap = (idx_inc >= size_reg) ? '0 : IDX_W'(idx_inc);

    // Forward distance modulo the active size, for both the entry's home and the hole.
    always_comb
    begin
        dist_home = (SIZE_W + 1)'(idx_reg) - (SIZE_W + 1)'(rd_home);
        if (idx_reg < rd_home)
        begin
            dist_home = dist_home + (SIZE_W + 1)'(size_reg);
        end
        dist_hole = (SIZE_W + 1)'(idx_reg) - (SIZE_W + 1)'(hole_reg);
        if (idx_reg < hole_reg)
        begin
            dist_hole = dist_hole + (SIZE_W + 1)'(size_reg);
        end
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            later_mask[k] = (k > int'(idx_reg)) && (k < int'(size_reg));
        end
    end

    always_comb
    begin
        stat.op        = op_reg;
        stat.mod_done  = mod_done;
        stat.n_end     = (n_reg == size_reg);
        stat.occ       = occ_reg[idx_reg];
        stat.key_match = (rd_key == key_reg);
        stat.can_move  = (dist_home >= dist_hole);
        stat.later_occ = |(occ_reg & later_mask);
        stat.out_free  = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        occ_next  = occ_reg;
        idx_next  = idx_reg;
        hole_next = hole_reg;
        n_next    = n_reg;
        if (cfg_we)
        begin
            occ_next = '0;
        end
        else
        begin
            if (cmd.store)
            begin
                occ_next[idx_reg] = 1'b1;
            end
            if (cmd.del_clear)
            begin
                occ_next[idx_reg] = 1'b0;
            end
            if (cmd.shift_move)
            begin
                occ_next[hole_reg] = 1'b1;
                occ_next[idx_reg]  = 1'b0;
            end
        end

        priority if (cmd.probe_init)
        begin
            idx_next = rem;
            n_next   = '0;
        end
        else if (cmd.dump_init)
        begin
            idx_next = '0;
            n_next   = '0;
        end
        else if (cmd.del_clear)
        begin
            hole_next = idx_reg;
            idx_next  = idx_wrap;
            n_next    = '0;
        end
        else if (cmd.advance)
        begin
            idx_next = idx_wrap;
            n_next   = n_reg + SIZE_W'(1);
            if (cmd.shift_move)
            begin
                hole_next = idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_size;
            end
            occ_reg <= occ_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        hole_reg <= hole_next;
        n_reg    <= n_next;
        if (cmd.load)
        begin
            op_reg   <= in_op;
            key_reg  <= in_key;
            text_reg <= in_text;
        end
        if (cmd.store)
        begin
            key_mem[idx_reg]  <= key_reg;
            text_mem[idx_reg] <= text_reg & TEXT_MASK;
            home_mem[idx_reg] <= rem;
        end
        if (cmd.shift_move)
        begin
            key_mem[hole_reg]  <= rd_key;
            text_mem[hole_reg] <= rd_text;
            home_mem[hole_reg] <= rd_home;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
            unique case (cmd.emit_src)
                SRC_ENTRY:
                begin
                    out_slot_reg <= SLOT_W'(idx_reg);
                    out_key_reg  <= rd_key;
                    out_text_reg <= rd_text;
                end
                SRC_INPUT:
                begin
                    out_slot_reg <= SLOT_W'(idx_reg);
                    out_key_reg  <= key_reg;
                    out_text_reg <= text_reg & TEXT_MASK;
                end
                default:
                begin
                    out_slot_reg <= '0;
                    out_key_reg  <= '0;
                    out_text_reg <= '0;
                end
            endcase
        end
    end

    assign size           = size_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.entry_key  = out_key_reg;
    assign rsp.entry_text = out_text_reg;
    assign rsp.last       = out_last_reg;

endmodule

// File: sv/linear_probing_hash_table.sv
// Open-addressing hash table with linear probing and backward-shift delete.
// Requests arrive on the req channel (operation, key, text); one beat is taken
// only while the block is idle. Results leave on the rsp channel, one beat per
// result, with last set on the final beat of a request. Add and delete give one
// beat, dump gives one beat per occupied slot (or one empty-table beat), and an
// unknown operation gives none.
// Timing: add and delete first reduce the key modulo the table size in a
// two-bits-per-cycle remainder unit, then probe one slot per cycle. A delete
// then walks the following slots, shifting entries back into the gap. A dump
// visits one slot per cycle unless the receiver holds back a result. The
// slot-per-cycle walk is set by the single read port on the entry store.
// The result sits in an output register; a stalled receiver just holds the
// sequencer at its next result while the rest waits.
// Reset empties the table at once (per-slot occupied flags) and sets the size
// to 16. A write to table_size over the APB port empties it the same way;
// only pwdata[4:0] is used, 0 reads as 1 and values above the depth are clamped.
module linear_probing_hash_table
    import lpht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lpht_req_if.sink    req,
    lpht_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t              cmd;
    stat_t             stat;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_raw;
    logic [SIZE_W-1:0] cfg_size;
    logic [SIZE_W-1:0] size;
    logic              in_ready;

    // The only register lives at offset zero; writes to any other offset are ignored.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && (paddr == 2'd0);
    assign cfg_raw = pwdata[SIZE_W-1:0];

    always_comb
    begin
        priority if (cfg_raw == '0)
        begin
            cfg_size = SIZE_W'(1);
        end
        else if (cfg_raw > SIZE_MAX)
        begin
            cfg_size = SIZE_MAX;
        end
        else
        begin
            cfg_size = cfg_raw;
        end
    end

    assign prdata    = 32'(size);
    assign req.ready = in_ready;

    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (op_t'(req.operation)),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lpht_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_size (cfg_size),
        .size     (size),
        .in_op    (op_t'(req.operation)),
        .in_key   (req.key),
        .in_text  (req.text),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule
